// ===== rtl/gocv_pkg.sv =====
// Shared types, constants and small lookup functions for the Gregorian
// ordinal date converter. Used by every module in rtl/; depends on nothing.
package gocv_pkg;

  // Pipeline depth shared by the top level and both datapaths.
  localparam int NumStages = 4;

  typedef logic [NumStages-1:0] stage_en_t;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StLowYear  = 2'd1,
    StBadMonth = 2'd2,
    StBadDay   = 2'd3
  } status_e;

  localparam logic [13:0] MinYear       = 14'd1900;
  localparam logic [14:0] YearOffsetA   = 15'd4800;
  localparam logic [14:0] YearOffsetB   = 15'd4900;
  localparam logic [10:0] DaysPerFour   = 11'd1461;
  localparam logic [15:0] JanTerm       = 16'd336;
  localparam logic [12:0] RecipHundred  = 13'd5243;
  localparam int          RecipShift    = 19;
  localparam logic [6:0]  Hundred       = 7'd100;
  localparam logic [11:0] BaseYear      = 12'd2000;
  localparam logic [7:0]  CenturyNoLeap = 8'd100;
  localparam logic [8:0]  CommonYearLen = 9'd365;
  localparam int          OrdLimit      = 999;

  // Floor of 367 * k / 12 for the month term of the day number formula.
  function automatic logic [9:0] month_term(input logic [4:0] k);
    logic [9:0] v;
    case (k)
      5'd1:    v = 10'd30;
      5'd2:    v = 10'd61;
      5'd3:    v = 10'd91;
      5'd4:    v = 10'd122;
      5'd5:    v = 10'd152;
      5'd6:    v = 10'd183;
      5'd7:    v = 10'd214;
      5'd8:    v = 10'd244;
      5'd9:    v = 10'd275;
      5'd10:   v = 10'd305;
      5'd11:   v = 10'd336;
      5'd12:   v = 10'd367;
      5'd13:   v = 10'd397;
      5'd14:   v = 10'd428;
      5'd15:   v = 10'd458;
      5'd16:   v = 10'd489;
      5'd17:   v = 10'd519;
      5'd18:   v = 10'd550;
      5'd19:   v = 10'd581;
      5'd20:   v = 10'd611;
      5'd21:   v = 10'd642;
      5'd22:   v = 10'd672;
      5'd23:   v = 10'd703;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // Days in a common year before the month with the given zero-based index.
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Leap test for a year given as an offset from 2000 (0..129).
  function automatic logic offset_leap(input logic [7:0] n);
    return (n[1:0] == 2'b00) && (n != CenturyNoLeap);
  endfunction

endpackage

// ===== rtl/gocv_to_ordinal.sv =====
// Calendar date to ordinal day datapath, four register stages.
// Depends on gocv_pkg; stage enables come from the top level.
module gocv_to_ordinal (
  input  logic                clk_i,
  input  gocv_pkg::stage_en_t stage_en_i,
  input  logic [13:0]         year_i,
  input  logic [6:0]          month_i,
  input  logic [6:0]          day_i,
  output logic [1:0]          status_o,
  output logic [6:0]          short_year_o,
  output logic signed [10:0]  ordinal_day_o
);

  // Stage 1: month adjustment, year offsets and range flags.
  logic signed [4:0] adj;
  logic signed [8:0] adj12;
  logic signed [8:0] k_full;
  logic [14:0] ya_d, yb_d;
  logic        dbad_d;

  logic [14:0] ya_q, yb_q, ya1_q, yb1_q;
  logic [13:0] y1_q;
  logic [4:0]  k_q;
  logic [6:0]  d1_q;
  logic        low1_q, badm1_q, dbad1_q, feb29_1_q;

  always_comb begin
    adj = 5'sd0;
    if (month_i <= 7'd2) begin
      adj = -5'sd1;
    end else begin
      for (int j = 0; j < 9; j++) begin
        if (month_i >= 7'(26 + 12 * j)) begin
          adj = adj + 5'sd1;
        end
      end
    end
    adj12  = 9'(adj) * 9'sd12;
    k_full = $signed({2'b00, month_i}) - 9'sd2 - adj12;
    ya_d   = 15'(year_i) + gocv_pkg::YearOffsetA + 15'(adj);
    yb_d   = 15'(year_i) + gocv_pkg::YearOffsetB + 15'(adj);
    dbad_d = (day_i == 7'd0) || (day_i > 7'd31) ||
             (((month_i == 7'd4) || (month_i == 7'd6) || (month_i == 7'd9) ||
               (month_i == 7'd11)) && (day_i > 7'd30)) ||
             ((month_i == 7'd2) && (day_i > 7'd29));
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      ya_q      <= ya_d;
      yb_q      <= yb_d;
      ya1_q     <= 15'(year_i) + gocv_pkg::YearOffsetA - 15'd1;
      yb1_q     <= 15'(year_i) + gocv_pkg::YearOffsetB - 15'd1;
      y1_q      <= year_i;
      k_q       <= k_full[4:0];
      d1_q      <= day_i;
      low1_q    <= year_i < gocv_pkg::MinYear;
      badm1_q   <= (month_i == 7'd0) || (month_i > 7'd12);
      dbad1_q   <= dbad_d;
      feb29_1_q <= (month_i == 7'd2) && (day_i == 7'd29);
    end
  end

  // Stage 2: constant multiplies; divisions by 100 use a reciprocal.
  logic [25:0] pa_full, pa1_full;
  logic [27:0] cb_full, cb1_full, cy_full;

  logic [24:0] pa_q, pa1_q;
  logic [7:0]  ca_q, ca1_q, cy_q;
  logic [9:0]  tk_q;
  logic [13:0] y2_q;
  logic [6:0]  d2_q;
  logic        low2_q, badm2_q, dbad2_q, feb29_2_q;

  always_comb begin
    pa_full  = 26'(ya_q) * 26'(gocv_pkg::DaysPerFour);
    pa1_full = 26'(ya1_q) * 26'(gocv_pkg::DaysPerFour);
    cb_full  = 28'(yb_q) * 28'(gocv_pkg::RecipHundred);
    cb1_full = 28'(yb1_q) * 28'(gocv_pkg::RecipHundred);
    cy_full  = 28'(y1_q) * 28'(gocv_pkg::RecipHundred);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      pa_q      <= pa_full[24:0];
      pa1_q     <= pa1_full[24:0];
      ca_q      <= cb_full[gocv_pkg::RecipShift +: 8];
      ca1_q     <= cb1_full[gocv_pkg::RecipShift +: 8];
      cy_q      <= cy_full[gocv_pkg::RecipShift +: 8];
      tk_q      <= gocv_pkg::month_term(k_q);
      y2_q      <= y1_q;
      d2_q      <= d1_q;
      low2_q    <= low1_q;
      badm2_q   <= badm1_q;
      dbad2_q   <= dbad1_q;
      feb29_2_q <= feb29_1_q;
    end
  end

  // Stage 3: difference of the two day numbers, year remainder, status.
  logic [22:0] dp_full;
  logic [9:0]  ca3, ca13, dc;
  logic signed [15:0] ord_d;
  logic [13:0] rem_full;
  logic        leap;
  logic [1:0]  status_d;

  logic signed [15:0] ord3_q;
  logic [6:0]  rem3_q;
  logic [1:0]  status3_q;

  always_comb begin
    dp_full  = pa_q[24:2] - pa1_q[24:2];
    ca3      = {2'b00, ca_q} + {1'b0, ca_q, 1'b0};
    ca13     = {2'b00, ca1_q} + {1'b0, ca1_q, 1'b0};
    dc       = {2'b00, ca3[9:2]} - {2'b00, ca13[9:2]};
    ord_d    = $signed(dp_full[15:0]) + $signed({6'b0, tk_q}) -
               $signed(gocv_pkg::JanTerm) - $signed({6'b0, dc}) +
               $signed({9'b0, d2_q});
    rem_full = y2_q - 14'(cy_q) * 14'(gocv_pkg::Hundred);
    leap     = (y2_q[1:0] == 2'b00) &&
               ((rem_full[6:0] != 7'd0) || (cy_q[1:0] == 2'b00));
    if (low2_q) begin
      status_d = gocv_pkg::StLowYear;
    end else if (badm2_q) begin
      status_d = gocv_pkg::StBadMonth;
    end else if (dbad2_q || (feb29_2_q && !leap)) begin
      status_d = gocv_pkg::StBadDay;
    end else begin
      status_d = gocv_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      ord3_q    <= ord_d;
      rem3_q    <= rem_full[6:0];
      status3_q <= status_d;
    end
  end

  // Stage 4: clamp the day of year to -999..999.
  logic signed [10:0] ord_sat;
  logic signed [10:0] ord4_q;
  logic [6:0]  rem4_q;
  logic [1:0]  status4_q;

  always_comb begin
    if (ord3_q > 16'(gocv_pkg::OrdLimit)) begin
      ord_sat = 11'(gocv_pkg::OrdLimit);
    end else if (ord3_q < -16'(gocv_pkg::OrdLimit)) begin
      ord_sat = -11'(gocv_pkg::OrdLimit);
    end else begin
      ord_sat = ord3_q[10:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      ord4_q    <= ord_sat;
      rem4_q    <= rem3_q;
      status4_q <= status3_q;
    end
  end

  assign status_o      = status4_q;
  assign short_year_o  = rem4_q;
  assign ordinal_day_o = ord4_q;

endmodule

// ===== rtl/gocv_from_ordinal.sv =====
// Ordinal day to calendar date datapath for years 2000 to 2127, four stages.
// Depends on gocv_pkg; stage enables come from the top level.
module gocv_from_ordinal (
  input  logic                clk_i,
  input  gocv_pkg::stage_en_t stage_en_i,
  input  logic [6:0]          short_year_i,
  input  logic [9:0]          day_of_year_i,
  output logic [11:0]         year_o,
  output logic [3:0]          month_o,
  output logic [4:0]          day_o
);

  // Stage 1: fold one year length off when the day runs past the year.
  logic [7:0]  n0;
  logic [8:0]  len0;
  logic        over0;

  logic [9:0]  d1_q;
  logic [7:0]  n1_q;
  logic        zero1_q;

  always_comb begin
    n0    = {1'b0, short_year_i};
    len0  = gocv_pkg::CommonYearLen + 9'(gocv_pkg::offset_leap(n0));
    over0 = day_of_year_i > {1'b0, len0};
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      d1_q    <= over0 ? (day_of_year_i - {1'b0, len0}) : day_of_year_i;
      n1_q    <= n0 + 8'(over0);
      zero1_q <= day_of_year_i == 10'd0;
    end
  end

  // Stage 2: a second fold covers days that reach two years ahead.
  logic [8:0]  len1;
  logic        over1;

  logic [8:0]  d2_q;
  logic [7:0]  n2_q;
  logic        zero2_q;

  always_comb begin
    len1  = gocv_pkg::CommonYearLen + 9'(gocv_pkg::offset_leap(n1_q));
    over1 = d1_q > {1'b0, len1};
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      d2_q    <= over1 ? 9'(d1_q - {1'b0, len1}) : d1_q[8:0];
      n2_q    <= n1_q + 8'(over1);
      zero2_q <= zero1_q;
    end
  end

  // Stage 3: month from parallel compares against month start days.
  logic        leap2;
  logic [10:0] past;
  logic [8:0]  thr;

  logic [3:0]  mon3_q;
  logic [8:0]  d3_q;
  logic [7:0]  n3_q;
  logic        zero3_q, leap3_q;

  always_comb begin
    leap2 = gocv_pkg::offset_leap(n2_q);
    thr   = 9'd0;
    for (int i = 1; i < 12; i++) begin
      thr         = gocv_pkg::cum_days(4'(i)) + 9'(leap2 && (i >= 2));
      past[i - 1] = d2_q > thr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      mon3_q  <= 4'd1 + 4'($countones(past));
      d3_q    <= d2_q;
      n3_q    <= n2_q;
      zero3_q <= zero2_q;
      leap3_q <= leap2;
    end
  end

  // Stage 4: day within the month; day zero means December 31 of the year before.
  logic [8:0]  base;
  logic [8:0]  dom;

  logic [11:0] year4_q;
  logic [3:0]  mon4_q;
  logic [4:0]  day4_q;

  always_comb begin
    base = gocv_pkg::cum_days(mon3_q - 4'd1) + 9'(leap3_q && (mon3_q >= 4'd3));
    dom  = d3_q - base;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      year4_q <= gocv_pkg::BaseYear + 12'(n3_q) - 12'(zero3_q);
      mon4_q  <= zero3_q ? 4'd12 : mon3_q;
      day4_q  <= zero3_q ? 5'd31 : dom[4:0];
    end
  end

  assign year_o  = year4_q;
  assign month_o = mon4_q;
  assign day_o   = day4_q;

endmodule

// ===== rtl/gregorian_ordinal_date_converter_top.sv =====
// Top level of the Gregorian ordinal date converter: pipeline control and result select.
// Depends on gocv_pkg, gocv_to_ordinal and gocv_from_ordinal.

// This block converts between calendar dates and ordinal days. With operation 0 an
// item carries a year, month and day; the result gives a status code (year below 1900,
// month outside 1 to 12, or a day the month does not have, February 29 counting only
// in leap years; the first failing check wins), the year modulo 100 and the one-based
// day of year, which is computed even for a bad date and clamped to -999..999. With
// operation 1 an item carries a year offset from 2000 and a day of year; the result is
// the calendar date, where day zero gives December 31 of the year before and days past
// the year's end roll into the following years. Fields that belong to the other
// operation read zero. The block is a four-stage pipeline: it accepts one item every
// clock cycle while the output is not stalled. Every stage holds a valid bit and
// advances whenever the stage after it is empty or moving, so a stall on the output
// only backs up stages that hold items, and empty stages still fill.
module gregorian_ordinal_date_converter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [13:0]        year_i,
  input  logic [6:0]         month_i,
  input  logic [6:0]         day_i,
  input  logic [6:0]         short_year_i,
  input  logic [9:0]         day_of_year_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [6:0]         ordinal_short_year_o,
  output logic signed [10:0] ordinal_day_o,
  output logic [11:0]        result_year_o,
  output logic [3:0]         result_month_o,
  output logic [4:0]         result_day_o
);

  localparam int Depth = gocv_pkg::NumStages;

  logic [Depth-1:0]    valid_q;
  logic [Depth-1:0]    op_q;
  logic [Depth:0]      ready;
  gocv_pkg::stage_en_t stage_en;

  // A stage may load when it is empty or when its content moves on this cycle.
  always_comb begin
    ready[Depth] = !out_stall_i;
    for (int k = Depth - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k + 1];
    end
    stage_en = ready[Depth-1:0];
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Depth; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k - 1];
        end
      end
    end
  end

  // The operation bit travels with its item to pick the result fields.
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      op_q[0] <= operation_i;
    end
    for (int k = 1; k < Depth; k++) begin
      if (stage_en[k]) begin
        op_q[k] <= op_q[k - 1];
      end
    end
  end

  logic [1:0]         ord_status;
  logic [6:0]         ord_short_year;
  logic signed [10:0] ord_day;
  logic [11:0]        date_year;
  logic [3:0]         date_month;
  logic [4:0]         date_day;

  gocv_to_ordinal u_to_ordinal (
    .clk_i         (clk_i),
    .stage_en_i    (stage_en),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .status_o      (ord_status),
    .short_year_o  (ord_short_year),
    .ordinal_day_o (ord_day)
  );

  gocv_from_ordinal u_from_ordinal (
    .clk_i         (clk_i),
    .stage_en_i    (stage_en),
    .short_year_i  (short_year_i),
    .day_of_year_i (day_of_year_i),
    .year_o        (date_year),
    .month_o       (date_month),
    .day_o         (date_day)
  );

  // Both datapaths run on every item; the last stage's operation bit zeroes the unused half.
  assign status_o             = op_q[Depth-1] ? gocv_pkg::StOk : ord_status;
  assign ordinal_short_year_o = op_q[Depth-1] ? 7'd0 : ord_short_year;
  assign ordinal_day_o        = op_q[Depth-1] ? 11'sd0 : ord_day;
  assign result_year_o        = op_q[Depth-1] ? date_year : 12'd0;
  assign result_month_o       = op_q[Depth-1] ? date_month : 4'd0;
  assign result_day_o         = op_q[Depth-1] ? date_day : 5'd0;

endmodule

// ===== sim/gocv_tb_pkg.sv =====
// Operation codes shared by the date converter testbench and its checker.
// Depends on nothing.
package gocv_tb_pkg;

  typedef enum logic {
    OpToOrdinal   = 1'b0,
    OpFromOrdinal = 1'b1
  } conv_op_e;

endpackage

// ===== sim/gocv_date_checker.sv =====
// Checker for the Gregorian ordinal date converter: predicts every result
// from the accepted input items and compares it with the block's output.
// Depends on gocv_pkg and gocv_tb_pkg.
module gocv_date_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               operation_i,
  input  logic [13:0]        year_i,
  input  logic [6:0]         month_i,
  input  logic [6:0]         day_i,
  input  logic [6:0]         short_year_i,
  input  logic [9:0]         day_of_year_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [6:0]         ordinal_short_year_i,
  input  logic signed [10:0] ordinal_day_i,
  input  logic [11:0]        result_year_i,
  input  logic [3:0]         result_month_i,
  input  logic [4:0]         result_day_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o
);

  typedef struct packed {
    gocv_pkg::status_e  status;
    logic [6:0]         short_year;
    logic signed [10:0] ordinal_day;
    logic [11:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
  } date_result_t;

  date_result_t expected_dates[$];
  date_result_t oldest;

  // Day number of a Gregorian date; all divisions truncate toward zero.
  function automatic longint day_number(input longint y, input longint m, input longint d);
    longint a;
    a = (m - 14) / 12;
    return (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
         - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
  endfunction

  function automatic bit leap_year(input longint y);
    return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
  endfunction

  function automatic date_result_t convert_date(input gocv_tb_pkg::conv_op_e op,
                                                input logic [13:0] year,
                                                input logic [6:0] month, input logic [6:0] day,
                                                input logic [6:0] short_year,
                                                input logic [9:0] day_of_year);
    date_result_t r;
    longint y, m, d, ord;
    longint jd, f, e, g, h, t, u, v;
    r = '0;
    r.status = gocv_pkg::StOk;
    if (op == gocv_tb_pkg::OpToOrdinal) begin
      y = year;
      m = month;
      d = day;
      ord = day_number(y, m, d) - day_number(y, 1, 1) + 1;
      if (ord > 999) ord = 999;
      if (ord < -999) ord = -999;
      if (y < 1900) r.status = gocv_pkg::StLowYear;
      else if (m < 1 || m > 12) r.status = gocv_pkg::StBadMonth;
      else if (d < 1 || d > 31) r.status = gocv_pkg::StBadDay;
      else if ((m == 4 || m == 6 || m == 9 || m == 11) && d > 30) r.status = gocv_pkg::StBadDay;
      else if (m == 2 && d > 29) r.status = gocv_pkg::StBadDay;
      else if (m == 2 && d > 28 && !leap_year(y)) r.status = gocv_pkg::StBadDay;
      r.short_year = 7'(y % 100);
      r.ordinal_day = ord[10:0];
    end else begin
      y = 2000 + longint'(short_year);
      jd = day_number(y, 1, 1) + longint'(day_of_year) - 1;
      f = jd + 68569;
      e = (4 * f) / 146097;
      g = f - (146097 * e + 3) / 4;
      h = (4000 * (g + 1)) / 1461001;
      t = g - (1461 * h) / 4 + 31;
      u = (80 * t) / 2447;
      v = u / 11;
      r.year = 12'(100 * (e - 49) + h + v);
      r.month = 4'(u + 2 - 12 * v);
      r.day = 5'(t - (2447 * u) / 80);
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_dates.delete();
      mismatch_count_o = 0;
      pending_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result item arrived with nothing expected", $time);
          mismatch_count_o++;
        end else begin
          oldest = expected_dates.pop_front();
          check_field("status", oldest.status, status_i);
          check_field("ordinal_short_year", oldest.short_year, ordinal_short_year_i);
          check_field("ordinal_day", oldest.ordinal_day, ordinal_day_i);
          check_field("result_year", oldest.year, result_year_i);
          check_field("result_month", oldest.month, result_month_i);
          check_field("result_day", oldest.day, result_day_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_dates.push_back(convert_date(gocv_tb_pkg::conv_op_e'(operation_i), year_i,
                                              month_i, day_i, short_year_i, day_of_year_i));
      end
      pending_count_o = expected_dates.size();
    end
  end

endmodule

// ===== sim/gregorian_ordinal_date_converter_top_tb.sv =====
// Testbench top for the Gregorian ordinal date converter: drives directed and
// random items with random gaps and output stalls, and gives the verdict.
// Depends on gocv_tb_pkg, gocv_date_checker and the converter RTL.
module gregorian_ordinal_date_converter_top_tb;

  // The slowest correct run sends roughly 525 items with the longest idle gaps and
  // output stalls; the limit leaves a wide margin over it.
  localparam int CycleLimit = 200000;
  localparam int RandomItems = 500;
  // The block is a four-stage pipeline; this covers its latency with room to spare.
  localparam int DrainCycles = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               operation_i;
  logic [13:0]        year_i;
  logic [6:0]         month_i;
  logic [6:0]         day_i;
  logic [6:0]         short_year_i;
  logic [9:0]         day_of_year_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [6:0]         ordinal_short_year_o;
  logic signed [10:0] ordinal_day_o;
  logic [11:0]        result_year_o;
  logic [3:0]         result_month_o;
  logic [4:0]         result_day_o;

  int mismatch_count;
  int pending_count;
  int cycle_count;

  // When set, the sender or the receiver stops idling, which gives stretches
  // where items move back to back through the pipeline.
  bit send_steady;
  bit drain_steady;

  gregorian_ordinal_date_converter_top i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .operation_i          (operation_i),
    .year_i               (year_i),
    .month_i              (month_i),
    .day_i                (day_i),
    .short_year_i         (short_year_i),
    .day_of_year_i        (day_of_year_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .ordinal_short_year_o (ordinal_short_year_o),
    .ordinal_day_o        (ordinal_day_o),
    .result_year_o        (result_year_o),
    .result_month_o       (result_month_o),
    .result_day_o         (result_day_o)
  );

  gocv_date_checker i_date_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .operation_i          (operation_i),
    .year_i               (year_i),
    .month_i              (month_i),
    .day_i                (day_i),
    .short_year_i         (short_year_i),
    .day_of_year_i        (day_of_year_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_i             (status_o),
    .ordinal_short_year_i (ordinal_short_year_o),
    .ordinal_day_i        (ordinal_day_o),
    .result_year_i        (result_year_o),
    .result_month_i       (result_month_o),
    .result_day_i         (result_day_o),
    .mismatch_count_o     (mismatch_count),
    .pending_count_o      (pending_count)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one item. The idle gap is drawn per item, and the valid stays high
  // from one item to the next when the gap is zero. All inputs change at the
  // falling edge, so the block and the checker see them settled at the rising edge.
  task automatic send_item(input gocv_tb_pkg::conv_op_e op, input logic [13:0] year,
                           input logic [6:0] month, input logic [6:0] day,
                           input logic [6:0] short_year, input logic [9:0] day_of_year);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    year_i = year;
    month_i = month;
    day_i = day;
    short_year_i = short_year;
    day_of_year_i = day_of_year;
    // The payload is held until the item is taken at a rising edge without stall.
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The random mix is mostly well-formed dates and day numbers in the range that
  // matters, with a share of fully random bit patterns for every field.
  task automatic send_random_item();
    int unsigned pick;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  short_year;
    logic [9:0]  day_of_year;
    pick = $urandom_range(99);
    year = 14'($urandom);
    month = 7'($urandom);
    day = 7'($urandom);
    short_year = 7'($urandom);
    day_of_year = 10'($urandom);
    if (pick < 45) begin
      year = 14'(($urandom_range(3) == 0) ? $urandom_range(9999, 1900) :
                                            $urandom_range(2199, 1896));
      month = 7'($urandom_range(12, 1));
      day = 7'($urandom_range(31, 1));
      send_item(gocv_tb_pkg::OpToOrdinal, year, month, day, short_year, day_of_year);
    end else if (pick < 55) begin
      send_item(gocv_tb_pkg::OpToOrdinal, year, month, day, short_year, day_of_year);
    end else if (pick < 90) begin
      short_year = 7'($urandom_range(99));
      day_of_year = 10'($urandom_range(366));
      send_item(gocv_tb_pkg::OpFromOrdinal, year, month, day, short_year, day_of_year);
    end else begin
      send_item(gocv_tb_pkg::OpFromOrdinal, year, month, day, short_year, day_of_year);
    end
  endtask

  // Holds the sender until every expected result has come out of the pipeline.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_count == 0);
  endtask

  // Receiver side: a stall of random length is drawn for each result item.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = drain_steady ? 0 : $urandom_range(7);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = gocv_tb_pkg::OpToOrdinal;
    year_i = '0;
    month_i = '0;
    day_i = '0;
    short_year_i = '0;
    day_of_year_i = '0;
    send_steady = 1'b0;
    drain_steady = 1'b0;
    cycle_count = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed dates: range limits, each status, and leap-year February.
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd1900, 7'd1, 7'd1, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd1899, 7'd12, 7'd31, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd0, 7'd0, 7'd0, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd9999, 7'd12, 7'd31, 7'd0, 10'd0);
    // All bits set: a month far beyond the calendar pushes the day of year
    // past the top of its range, so it saturates.
    send_item(gocv_tb_pkg::OpToOrdinal, 14'h3fff, 7'h7f, 7'h7f, 7'h7f, 10'h3ff);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2023, 7'd127, 7'd127, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2000, 7'd13, 7'd1, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2000, 7'd0, 7'd10, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2000, 7'd2, 7'd29, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd1900, 7'd2, 7'd29, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2100, 7'd2, 7'd29, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2023, 7'd2, 7'd29, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2024, 7'd2, 7'd30, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2023, 7'd4, 7'd31, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2023, 7'd1, 7'd32, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpToOrdinal, 14'd2023, 7'd1, 7'd0, 7'd0, 10'd0);

    // Directed day numbers: day zero falls back to the previous December 31,
    // the end of a leap year, and days past the year's end roll over.
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'd0, 7'd0, 7'd0, 7'd0, 10'd0);
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'd0, 7'd0, 7'd0, 7'd0, 10'd1);
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'd0, 7'd0, 7'd0, 7'd0, 10'd366);
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'd0, 7'd0, 7'd0, 7'd1, 10'd366);
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'd0, 7'd0, 7'd0, 7'd100, 10'd60);
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'd0, 7'd0, 7'd0, 7'd99, 10'h3ff);
    send_item(gocv_tb_pkg::OpFromOrdinal, 14'h3fff, 7'h7f, 7'h7f, 7'h7f, 10'h3ff);

    wait_for_drain();

    // Random phases: each hundred items picks whether the sender or the
    // receiver idles, so gaps and back-to-back stretches both occur.
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        send_steady = (i == 200) || (i == 300);
        drain_steady = (i == 200) || (i == 400);
      end
      if (i == RandomItems / 2) wait_for_drain();
      send_random_item();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_count == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gocv_pkg.sv
rtl/gocv_to_ordinal.sv
rtl/gocv_from_ordinal.sv
rtl/gregorian_ordinal_date_converter_top.sv
sim/gocv_tb_pkg.sv
sim/gocv_date_checker.sv
sim/gregorian_ordinal_date_converter_top_tb.sv
